/* hdl/tmva_pkg.sv */
// Package for the triangle mixed area block: widths, region codes and the tag
// that travels beside each word. No dependencies.
`default_nettype none

package tmva_pkg;

  // Default coordinate format and the fixed result width
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned AREA_BITS  = 48;

  // Corner selector codes; the last code shares the arm of corner two
  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;
  localparam logic [1:0] CORNER_3 = 2'd3;

  // Which area rule applies
  typedef enum logic [1:0] {
    KIND_VORONOI     = 2'd0,
    KIND_OBTUSE_AT   = 2'd1,
    KIND_OBTUSE_ELSE = 2'd2
  } kind_e;

  // Per-word control that rides along the pipeline
  typedef struct packed {
    kind_e kind;
    logic  degen;
  } tag_t;

endpackage

`default_nettype wire

/* hdl/tmva_geom.sv */
// Front pipeline: edge vectors, dot and cross products, squared cross sum and
// cotangent numerator. Five register stages. Depends on tmva_pkg.
`default_nettype none

module tmva_geom import tmva_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  logic [2:0][2:0][CoordBits-1:0]            pt_i,
  input  logic [1:0]                                corner_i,
  output logic                                      valid_o,
  output logic [2*(2*(CoordBits+1))+1:0]            s_o,
  output logic [2*(2*(CoordBits+1)):0]              n_o,
  output tag_t                                      tag_o
);

  localparam int unsigned DW   = CoordBits + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned DOTW = PW + 2;
  localparam int unsigned XW   = PW + 1;
  localparam int unsigned XM   = PW;
  localparam int unsigned SW   = 2 * XM + 2;
  localparam int unsigned NW   = 2 * PW + 1;
  localparam int unsigned L    = (XM + 1) / 2;
  localparam int unsigned HW   = XM - L;
  localparam int unsigned L2   = (PW + 1) / 2;
  localparam int unsigned H2   = PW - L2;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: pick corners in cyclic order and form edge vectors
  logic [1:0] ia, ib, ic;
  logic signed [DW-1:0] ab_d [3], ac_d [3], bc_d [3];
  logic signed [DW-1:0] ab_q [3], ac_q [3], bc_q [3];

  always_comb begin
    unique case (corner_i)
      CORNER_0: begin ia = 2'd0; ib = 2'd1; ic = 2'd2; end
      CORNER_1: begin ia = 2'd1; ib = 2'd2; ic = 2'd0; end
      default:  begin ia = 2'd2; ib = 2'd0; ic = 2'd1; end
    endcase
    for (int k = 0; k < 3; k++) begin
      ab_d[k] = DW'($signed(pt_i[ib][k])) - DW'($signed(pt_i[ia][k]));
      ac_d[k] = DW'($signed(pt_i[ic][k])) - DW'($signed(pt_i[ia][k]));
      bc_d[k] = DW'($signed(pt_i[ic][k])) - DW'($signed(pt_i[ib][k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q <= ab_d;
      ac_q <= ac_d;
      bc_q <= bc_d;
    end
  end

  // Stage 2: all component products
  logic signed [PW-1:0] pabac_q [3], pabbc_q [3], pacbc_q [3];
  logic signed [PW-1:0] pabab_q [3], pacac_q [3], px_q [6];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pabac_q[k] <= ab_q[k] * ac_q[k];
        pabbc_q[k] <= ab_q[k] * bc_q[k];
        pacbc_q[k] <= ac_q[k] * bc_q[k];
        pabab_q[k] <= ab_q[k] * ab_q[k];
        pacac_q[k] <= ac_q[k] * ac_q[k];
      end
      px_q[0] <= ab_q[1] * ac_q[2];
      px_q[1] <= ab_q[2] * ac_q[1];
      px_q[2] <= ab_q[2] * ac_q[0];
      px_q[3] <= ab_q[0] * ac_q[2];
      px_q[4] <= ab_q[0] * ac_q[1];
      px_q[5] <= ab_q[1] * ac_q[0];
    end
  end

  // Stage 3: dot products, obtuse test, cross magnitudes
  logic signed [DOTW-1:0] da, dbn, db, dc, lab_s, lac_s;
  logic signed [XW-1:0]   cx [3];
  logic [XM-1:0]          cm_d [3], cm_q [3];
  kind_e                  kind_d, kind3_q, kind4_q, kind5_q;
  logic [PW-1:0]          lab_q, lac_q, dbu_q, dcu_q;

  always_comb begin
    da    = DOTW'(pabac_q[0]) + DOTW'(pabac_q[1]) + DOTW'(pabac_q[2]);
    dbn   = DOTW'(pabbc_q[0]) + DOTW'(pabbc_q[1]) + DOTW'(pabbc_q[2]);
    dc    = DOTW'(pacbc_q[0]) + DOTW'(pacbc_q[1]) + DOTW'(pacbc_q[2]);
    lab_s = DOTW'(pabab_q[0]) + DOTW'(pabab_q[1]) + DOTW'(pabab_q[2]);
    lac_s = DOTW'(pacac_q[0]) + DOTW'(pacac_q[1]) + DOTW'(pacac_q[2]);
    db    = -dbn;
    if (da < 0) begin
      kind_d = KIND_OBTUSE_AT;
    end else if (db < 0 || dc < 0) begin
      kind_d = KIND_OBTUSE_ELSE;
    end else begin
      kind_d = KIND_VORONOI;
    end
    for (int j = 0; j < 3; j++) begin
      cx[j]   = XW'(px_q[2*j]) - XW'(px_q[2*j+1]);
      cm_d[j] = cx[j][XW-1] ? XM'(-cx[j]) : XM'(cx[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind3_q <= kind_d;
      cm_q    <= cm_d;
      lab_q   <= lab_s[PW-1:0];
      lac_q   <= lac_s[PW-1:0];
      // Numerator terms only matter for the Voronoi rule; zero them otherwise
      dbu_q   <= (kind_d == KIND_VORONOI) ? db[PW-1:0] : '0;
      dcu_q   <= (kind_d == KIND_VORONOI) ? dc[PW-1:0] : '0;
    end
  end

  // Stage 4: split squares and numerator products into half-width pieces
  logic [2*HW-1:0]  hh_q [3];
  logic [HW+L-1:0]  hl_q [3];
  logic [2*L-1:0]   ll_q [3];
  logic [2*H2-1:0]  nhh_q [2];
  logic [H2+L2-1:0] nhl_q [2], nlh_q [2];
  logic [2*L2-1:0]  nll_q [2];
  logic             degen4_q, degen5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        hh_q[j] <= cm_q[j][XM-1:L] * cm_q[j][XM-1:L];
        hl_q[j] <= cm_q[j][XM-1:L] * cm_q[j][L-1:0];
        ll_q[j] <= cm_q[j][L-1:0] * cm_q[j][L-1:0];
      end
      nhh_q[0] <= lab_q[PW-1:L2] * dcu_q[PW-1:L2];
      nhl_q[0] <= lab_q[PW-1:L2] * dcu_q[L2-1:0];
      nlh_q[0] <= lab_q[L2-1:0] * dcu_q[PW-1:L2];
      nll_q[0] <= lab_q[L2-1:0] * dcu_q[L2-1:0];
      nhh_q[1] <= lac_q[PW-1:L2] * dbu_q[PW-1:L2];
      nhl_q[1] <= lac_q[PW-1:L2] * dbu_q[L2-1:0];
      nlh_q[1] <= lac_q[L2-1:0] * dbu_q[PW-1:L2];
      nll_q[1] <= lac_q[L2-1:0] * dbu_q[L2-1:0];
      degen4_q <= (cm_q[0] == '0) && (cm_q[1] == '0) && (cm_q[2] == '0);
      kind4_q  <= kind3_q;
    end
  end

  // Stage 5: recombine pieces into the squared cross sum and the numerator
  logic [SW-1:0] s_d, s_q;
  logic [NW-1:0] n_d, n_q;

  always_comb begin
    s_d = '0;
    for (int j = 0; j < 3; j++) begin
      s_d = s_d + (SW'(hh_q[j]) << (2*L)) + (SW'(hl_q[j]) << (L+1)) + SW'(ll_q[j]);
    end
    n_d = '0;
    for (int j = 0; j < 2; j++) begin
      n_d = n_d + (NW'(nhh_q[j]) << (2*L2)) + (NW'(nhl_q[j]) << L2)
          + (NW'(nlh_q[j]) << L2) + NW'(nll_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q      <= s_d;
      n_q      <= n_d;
      kind5_q  <= kind4_q;
      degen5_q <= degen4_q;
    end
  end

  assign valid_o     = v5_q;
  assign s_o         = s_q;
  assign n_o         = n_q;
  assign tag_o.kind  = kind5_q;
  assign tag_o.degen = degen5_q;

endmodule

`default_nettype wire

/* hdl/tmva_sqrt.sv */
// Pipelined floor square root, one root bit per register stage, with a
// sideband word carried alongside. Depends on tmva_pkg.
`default_nettype none

module tmva_sqrt import tmva_pkg::*; #(
  parameter int unsigned RootW = 2 * (COORD_BITS + 1) + 1,
  parameter int unsigned SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2*RootW-1:0]   s_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [RootW-1:0]     root_o,
  output logic [SideW-1:0]     side_o
);

  localparam int unsigned SW  = 2 * RootW;
  localparam int unsigned RMW = RootW + 2;

  logic                v_q    [1:RootW];
  logic [SW-1:0]       s_q    [1:RootW];
  logic [RMW-1:0]      rem_q  [1:RootW];
  logic [RootW-1:0]    root_q [1:RootW];
  logic [SideW-1:0]    side_q [1:RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic             v_in;
    logic [SW-1:0]    s_in;
    logic [RMW-1:0]   rem_in, remx, trial;
    logic [RootW-1:0] root_in;
    logic [SideW-1:0] side_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign s_in    = s_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k];
      assign s_in    = s_q[k];
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
      assign side_in = side_q[k];
    end

    // Bring down two radicand bits and try the next root bit
    assign remx  = {rem_in[RMW-3:0], s_in[SW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1]    <= s_in << 2;
        rem_q[k+1]  <= ge ? (remx - trial) : remx;
        root_q[k+1] <= {root_in[RootW-2:0], ge};
        side_q[k+1] <= side_in;
      end
    end
  end

  assign valid_o = v_q[RootW];
  assign root_o  = root_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

`default_nettype wire

/* hdl/tmva_div.sv */
// Pipelined restoring divider for the Voronoi rule, shifted areas for the
// obtuse rules, saturation and the output register. Depends on tmva_pkg.
`default_nettype none

module tmva_div import tmva_pkg::*; #(
  parameter int unsigned RootW    = 2 * (COORD_BITS + 1) + 1,
  parameter int unsigned NumW     = 2 * (2 * (COORD_BITS + 1)) + 1,
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [RootW-1:0]      m_i,
  input  logic [NumW-1:0]       n_i,
  input  tag_t                  tag_i,
  output logic                  valid_o,
  output logic [AREA_BITS-1:0]  area_o,
  output tag_t                  tag_o
);

  localparam int unsigned AW  = AREA_BITS;
  localparam int unsigned SHW = RootW + FracBits + 3 + AW;
  localparam int unsigned EW  = ((NumW > SHW) ? NumW : SHW) + 1;

  // Prep stage: scaled divisor, overflow test, obtuse-rule areas
  logic          vp_q;
  logic [EW-1:0] remp_q, dshp_q, sh_w;
  logic          satp_q;
  logic [AW-1:0] obtp_q, obt_d;
  tag_t          tagp_q;

  always_comb begin
    if (tag_i.kind == KIND_OBTUSE_AT) begin
      sh_w = EW'(m_i) >> (FracBits + 2);
    end else begin
      sh_w = EW'(m_i) >> (FracBits + 3);
    end
    obt_d = (|sh_w[EW-1:AW]) ? '1 : sh_w[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      remp_q <= EW'(n_i);
      dshp_q <= EW'(m_i) << (FracBits + 3);
      satp_q <= EW'(n_i) >= (EW'(m_i) << (FracBits + 3 + AW));
      obtp_q <= obt_d;
      tagp_q <= tag_i;
    end
  end

  // Restoring steps, most significant quotient bit first
  logic          v_q   [1:AW];
  logic [EW-1:0] rem_q [1:AW];
  logic [EW-1:0] dsh_q [1:AW];
  logic [AW-1:0] quo_q [1:AW];
  logic          sat_q [1:AW];
  logic [AW-1:0] obt_q [1:AW];
  tag_t          tag_q [1:AW];

  for (genvar j = 0; j < AW; j++) begin : g_step
    localparam int unsigned B = AW - 1 - j;
    logic          v_in, sat_in, ge;
    logic [EW-1:0] rem_in, dsh_in, dsb;
    logic [AW-1:0] quo_in, obt_in;
    tag_t          tag_in;

    if (j == 0) begin : g_first
      assign v_in   = vp_q;
      assign rem_in = remp_q;
      assign dsh_in = dshp_q;
      assign quo_in = '0;
      assign sat_in = satp_q;
      assign obt_in = obtp_q;
      assign tag_in = tagp_q;
    end else begin : g_next
      assign v_in   = v_q[j];
      assign rem_in = rem_q[j];
      assign dsh_in = dsh_q[j];
      assign quo_in = quo_q[j];
      assign sat_in = sat_q[j];
      assign obt_in = obt_q[j];
      assign tag_in = tag_q[j];
    end

    assign dsb = dsh_in << B;
    assign ge  = (rem_in >= dsb);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? (rem_in - dsb) : rem_in;
        dsh_q[j+1] <= dsh_in;
        quo_q[j+1] <= quo_in | (AW'(ge) << B);
        sat_q[j+1] <= sat_in;
        obt_q[j+1] <= obt_in;
        tag_q[j+1] <= tag_in;
      end
    end
  end

  // Output register: pick the rule's area, zero for a flat triangle
  logic          vo_q;
  logic [AW-1:0] area_d, area_q;
  tag_t          tago_q;

  always_comb begin
    if (tag_q[AW].degen) begin
      area_d = '0;
    end else if (tag_q[AW].kind == KIND_VORONOI) begin
      area_d = sat_q[AW] ? '1 : quo_q[AW];
    end else begin
      area_d = obt_q[AW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[AW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      area_q <= area_d;
      tago_q <= tag_q[AW];
    end
  end

  assign valid_o = vo_q;
  assign area_o  = area_q;
  assign tag_o   = tago_q;

endmodule

`default_nettype wire

/* hdl/triangle_mixed_voronoi_area.sv */
// Top level of the triangle mixed area block: geometry front end, square
// root and divider pipelines. Depends on tmva_pkg, tmva_geom, tmva_sqrt, tmva_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word per cycle while ready:
//   three corners in signed fixed point and the index of the corner of interest.
//   Output channel (out_valid_o / out_ready_i) returns one word per input:
//   the corner's mixed area share (unsigned, saturating), the rule used and a
//   flag for a zero-area triangle (area then 0).
//   Throughput: one word per cycle while the output is not held. Stages with
//   the default 32-bit corners: 5 geometry stages + 67 square-root stages (one
//   root bit each) + 50 divider stages (prep, 48 quotient bits, output).
//   The whole pipeline moves on one enable: when the output word is held by
//   the receiver, every stage holds and in_ready_o drops; nothing is lost.
//   Reset clears all valid bits; no words are in flight afterwards.
`default_nettype none

module triangle_mixed_voronoi_area import tmva_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS,
  parameter int unsigned FracBits  = FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CoordBits-1:0]  p0_x_i,
  input  logic [CoordBits-1:0]  p0_y_i,
  input  logic [CoordBits-1:0]  p0_z_i,
  input  logic [CoordBits-1:0]  p1_x_i,
  input  logic [CoordBits-1:0]  p1_y_i,
  input  logic [CoordBits-1:0]  p1_z_i,
  input  logic [CoordBits-1:0]  p2_x_i,
  input  logic [CoordBits-1:0]  p2_y_i,
  input  logic [CoordBits-1:0]  p2_z_i,
  input  logic [1:0]            corner_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [AREA_BITS-1:0]  area_o,
  output logic [1:0]            region_kind_o,
  output logic                  degenerate_o
);

  localparam int unsigned DW    = CoordBits + 1;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned XM    = PW;
  localparam int unsigned SW    = 2 * XM + 2;
  localparam int unsigned RW    = SW / 2;
  localparam int unsigned NW    = 2 * PW + 1;
  localparam int unsigned TAGW  = $bits(tag_t);
  localparam int unsigned SIDEW = NW + TAGW;

  logic                         en;
  logic [2:0][2:0][CoordBits-1:0] pt;
  logic                         geo_valid, sq_valid;
  logic [SW-1:0]                geo_s;
  logic [NW-1:0]                geo_n, sq_n;
  tag_t                         geo_tag, sq_tag, out_tag;
  logic [SIDEW-1:0]             sq_side;
  logic [RW-1:0]                sq_root;

  // Hold every stage while the output word waits
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign pt[0][0] = p0_x_i;
  assign pt[0][1] = p0_y_i;
  assign pt[0][2] = p0_z_i;
  assign pt[1][0] = p1_x_i;
  assign pt[1][1] = p1_y_i;
  assign pt[1][2] = p1_z_i;
  assign pt[2][0] = p2_x_i;
  assign pt[2][1] = p2_y_i;
  assign pt[2][2] = p2_z_i;

  tmva_geom #(
    .CoordBits (CoordBits)
  ) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i && in_ready_o),
    .pt_i     (pt),
    .corner_i (corner_i),
    .valid_o  (geo_valid),
    .s_o      (geo_s),
    .n_o      (geo_n),
    .tag_o    (geo_tag)
  );

  tmva_sqrt #(
    .RootW (RW),
    .SideW (SIDEW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_valid),
    .s_i     (geo_s),
    .side_i  ({geo_n, geo_tag}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign sq_n   = sq_side[SIDEW-1:TAGW];
  assign sq_tag = tag_t'(sq_side[TAGW-1:0]);

  tmva_div #(
    .RootW    (RW),
    .NumW     (NW),
    .FracBits (FracBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .m_i     (sq_root),
    .n_i     (sq_n),
    .tag_i   (sq_tag),
    .valid_o (out_valid_o),
    .area_o  (area_o),
    .tag_o   (out_tag)
  );

  assign region_kind_o = out_tag.kind;
  assign degenerate_o  = out_tag.degen;

  // A flat triangle always reports zero area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> area_o == '0)
    else $error("degenerate word with nonzero area");

  // A held output word must stall the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // Hold a stalled output word steady until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(area_o) && $stable(out_tag))
    else $error("stalled output word changed");

endmodule

`default_nettype wire

/* tb/tb_triangle_mixed_voronoi_area.sv */
// Self-checking testbench for triangle_mixed_voronoi_area: a directed table, then
// random triangles, scored against typed expectations or an exact wide-integer area predictor.
// Depends on tmva_pkg and the triangle_mixed_voronoi_area RTL.
`default_nettype none

module tb_triangle_mixed_voronoi_area import tmva_pkg::*;;

  localparam int Q         = 65536;
  localparam int N_RANDOM  = 1250;
  localparam int HOLD_LEN  = 300;
  localparam int DRAIN_LEN = 140;

  typedef struct packed {
    logic [8:0][COORD_BITS-1:0] c;  // p0_x, p0_y, p0_z, p1_x, ... p2_z
    logic [1:0]                 corner;
  } tri_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] area;
    kind_e                kind;
    logic                 degen;
  } share_t;

  typedef struct packed {
    tri_t   t;
    bit     typed;
    share_t want;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [COORD_BITS-1:0] p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i;
  logic [COORD_BITS-1:0] p2_x_i, p2_y_i, p2_z_i;
  logic [1:0] corner_i;
  logic [AREA_BITS-1:0] area_o;
  logic [1:0] region_kind_o;
  logic degenerate_o;

  share_t pending_shares[$];
  int     n_errors  = 0;
  int     n_sent    = 0;
  int     n_checked = 0;
  bit     send_done = 0;

  triangle_mixed_voronoi_area uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact mixed area share of the selected corner
  function automatic share_t mixed_share(tri_t t);
    logic signed [255:0] p[3][3];
    logic signed [255:0] ab[3], ac[3], bc[3];
    logic signed [255:0] da, db, dc, s, cx, cy, cz, num;
    logic [255:0] m, trial, q;
    int ia, ib, ic;
    share_t r;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) p[k][i] = $signed(t.c[k*3+i]);
    case (t.corner)
      CORNER_0: begin ia = 0; ib = 1; ic = 2; end
      CORNER_1: begin ia = 1; ib = 2; ic = 0; end
      default:  begin ia = 2; ib = 0; ic = 1; end
    endcase
    for (int i = 0; i < 3; i++) begin
      ab[i] = p[ib][i] - p[ia][i];
      ac[i] = p[ic][i] - p[ia][i];
      bc[i] = p[ic][i] - p[ib][i];
    end
    da = ab[0]*ac[0] + ab[1]*ac[1] + ab[2]*ac[2];
    db = -(ab[0]*bc[0] + ab[1]*bc[1] + ab[2]*bc[2]);
    dc = ac[0]*bc[0] + ac[1]*bc[1] + ac[2]*bc[2];
    if (da < 0) r.kind = KIND_OBTUSE_AT;
    else if (db < 0 || dc < 0) r.kind = KIND_OBTUSE_ELSE;
    else r.kind = KIND_VORONOI;
    cx = ab[1]*ac[2] - ab[2]*ac[1];
    cy = ab[2]*ac[0] - ab[0]*ac[2];
    cz = ab[0]*ac[1] - ab[1]*ac[0];
    s = cx*cx + cy*cy + cz*cz;
    r.area  = '0;
    r.degen = (s == 0);
    if (r.degen) return r;
    // floor square root, one bit at a time
    m = '0;
    for (int b = 127; b >= 0; b--) begin
      trial = m | (256'd1 << b);
      if (trial * trial <= s) m = trial;
    end
    if (r.kind == KIND_VORONOI) begin
      num = (ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2]) * dc
          + (ac[0]*ac[0] + ac[1]*ac[1] + ac[2]*ac[2]) * db;
      q = num / (m << (FRAC_BITS + 3));
    end else begin
      q = m >> (FRAC_BITS + ((r.kind == KIND_OBTUSE_AT) ? 2 : 3));
    end
    r.area = ((q >> AREA_BITS) != 0) ? '1 : q[AREA_BITS-1:0];
    return r;
  endfunction

  function automatic tri_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                    int x2, int y2, int z2, logic [1:0] cn);
    tri_t t;
    t.c = {x0, y0, z0, x1, y1, z1, x2, y2, z2};
    t.c = {t.c[0], t.c[1], t.c[2], t.c[3], t.c[4], t.c[5], t.c[6], t.c[7], t.c[8]};
    t.corner = cn;
    return t;
  endfunction

  function automatic int rand_coord(int span);
    return int'($urandom_range(2*span)) - span;
  endfunction

  // Random triangle, mostly small well-formed shapes, some full range and flat ones
  function automatic tri_t random_tri();
    tri_t t;
    int   mode, span;
    logic [COORD_BITS-1:0] v;
    mode = $urandom_range(99);
    span = (1 << $urandom_range(8, 22));
    for (int i = 0; i < 9; i++) t.c[i] = (mode < 25) ? $urandom() : rand_coord(span);
    t.corner = $urandom_range(3);
    if (mode >= 85) begin
      // flatten: repeat a corner or extend an edge
      for (int i = 0; i < 3; i++) begin
        v = (mode >= 93) ? t.c[i] : 2*t.c[3+i] - t.c[i];
        t.c[6+i] = v;
      end
    end
    return t;
  endfunction

  task automatic send_word(tri_t t);
    // idle now and then, except in the quiet stretch
    while (!(n_sent >= 200 && n_sent < 500) && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    {p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i, p2_x_i, p2_y_i, p2_z_i} <=
      {t.c[0], t.c[1], t.c[2], t.c[3], t.c[4], t.c[5], t.c[6], t.c[7], t.c[8]};
    corner_i   <= t.corner;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
  endtask

  // Sender: directed table, then random words
  initial begin
    row_t rows[16];
    row_t rw;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    {p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i, p2_x_i, p2_y_i, p2_z_i} <= '0;
    corner_i   <= CORNER_0;
    rows[0]  = '{make_tri(0,0,0, 0,0,0, 0,0,0, CORNER_0), 1,
                 '{'0, KIND_VORONOI, 1'b1}};
    rows[1]  = '{make_tri(32'h7fffffff,32'h7fffffff,32'h7fffffff, 32'h7fffffff,32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff,32'h7fffffff,32'h7fffffff, CORNER_1), 1,
                 '{'0, KIND_VORONOI, 1'b1}};
    rows[2]  = '{make_tri(32'h80000000,32'h80000000,32'h80000000, 32'h80000000,32'h80000000,
                 32'h80000000, 32'h80000000,32'h80000000,32'h80000000, CORNER_2), 1,
                 '{'0, KIND_VORONOI, 1'b1}};
    rows[3]  = '{make_tri(0,0,0, Q,0,0, 2*Q,0,0, CORNER_0), 1,
                 '{'0, KIND_OBTUSE_ELSE, 1'b1}};
    rows[4]  = '{make_tri(0,0,0, Q,0,0, 2*Q,0,0, CORNER_1), 1,
                 '{'0, KIND_OBTUSE_AT, 1'b1}};
    rows[5]  = '{make_tri(0,0,0, Q,0,0, 0,Q,0, CORNER_0), 0, '0};
    rows[6]  = '{make_tri(0,0,0, Q,0,0, 0,Q,0, CORNER_1), 0, '0};
    rows[7]  = '{make_tri(0,0,0, Q,0,0, 0,Q,0, CORNER_2), 0, '0};
    rows[8]  = '{make_tri(0,0,0, Q,0,0, 0,Q,0, CORNER_3), 0, '0};
    rows[9]  = '{make_tri(0,0,0, 4*Q,Q,0, -4*Q,Q,0, CORNER_0), 0, '0};
    rows[10] = '{make_tri(0,0,0, 4*Q,Q,0, -4*Q,Q,0, CORNER_1), 0, '0};
    rows[11] = '{make_tri(Q,0,0, 0,Q,0, 0,0,Q, CORNER_0), 0, '0};
    rows[12] = '{make_tri(32'h80000000,32'h80000000,32'h80000000, 32'h7fffffff,32'h80000000,0,
                 32'h80000000,32'h7fffffff,32'h7fffffff, CORNER_1), 0, '0};
    rows[13] = '{make_tri(32'h80000000,32'h80000000,32'h80000000, 32'h7fffffff,32'h80000000,0,
                 32'h80000000,32'h7fffffff,32'h7fffffff, CORNER_0), 0, '0};
    rows[14] = '{make_tri(32'h7fffffff,32'h7fffffff,32'h7fffffff, 32'h80000000,0,32'h7fffffff,
                 0,32'h80000000,32'h80000000, CORNER_2), 0, '0};
    rows[15] = '{make_tri(32'h7fffffff,32'h7fffffff,32'h7fffffff, 32'h80000000,0,32'h7fffffff,
                 0,32'h80000000,32'h80000000, CORNER_3), 0, '0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[k]) begin
      rw = rows[k];
      send_word(rw.t);
      pending_shares.push_back(rw.typed ? rw.want : mixed_share(rw.t));
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      rw.t = random_tri();
      send_word(rw.t);
      pending_shares.push_back(mixed_share(rw.t));
    end
    in_valid_i <= 1'b0;
    send_done = 1;
  end

  // Receiver: score each word, stall at random, and hold off once for a long stretch
  initial begin
    int  hold_left;
    bit  held;
    share_t exp_s;
    hold_left = 0;
    held      = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_shares.size() == 0) begin
          $error("unexpected word: area=%0h kind=%0d degenerate=%0b",
                 area_o, region_kind_o, degenerate_o);
          n_errors++;
        end else begin
          exp_s = pending_shares.pop_front();
          if (area_o !== exp_s.area) begin
            $error("area: expected %0h actual %0h", exp_s.area, area_o);
            n_errors++;
          end
          if (region_kind_o !== exp_s.kind) begin
            $error("region_kind: expected %0d actual %0d", exp_s.kind, region_kind_o);
            n_errors++;
          end
          if (degenerate_o !== exp_s.degen) begin
            $error("degenerate: expected %0b actual %0b", exp_s.degen, degenerate_o);
            n_errors++;
          end
          n_checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held && n_checked >= 700) begin
        held      = 1;
        hold_left = HOLD_LEN;
        out_ready_i <= 1'b0;
      end else if (n_checked >= 200 && n_checked < 500) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 11);
      end
    end
  end

  // Drain, then report
  initial begin
    wait (send_done);
    while (pending_shares.size() != 0) @(posedge clk_i);
    repeat (DRAIN_LEN) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
